// ----- hdl/bbrc_pkg.sv -----
// Shared types and constants for the buddy block range carver.
// Holds the action codes, command and status structs and default sizes.
// No dependencies; every other file in hdl uses it by scoped names.
package bbrc_pkg;

  localparam int ORDER_COUNT_DEF = 11;
  localparam int PAGE_BITS_DEF   = 36;
  localparam int ORDER_W         = 4;
  localparam int KIND_W          = 2;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_PAGE   = 1'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_UNTOUCHED = 2'd0,
    KIND_REMOVE    = 2'd1,
    KIND_DOMAIN    = 2'd2,
    KIND_GLOBAL    = 2'd3
  } kind_e;

  typedef struct packed {
    logic  load;
    logic  emit;
    kind_e kind;
    logic  last;
    logic  advance;
    logic  descend;
  } cmd_t;

  typedef struct packed {
    logic order_bad;
    logic outside;
    logic in_range;
    logic at_end;
    logic out_free;
    logic level_zero;
  } sts_t;

endpackage

// ----- hdl/bbrc_dp.sv -----
// Datapath of the buddy block range carver: domain registers, the current
// tree node walker, range classification and the output word register.
// Depends on bbrc_pkg; driven by bbrc_ctrl through cmd_t and sts_t.
module bbrc_dp #(
  parameter int ORDER_COUNT      = bbrc_pkg::ORDER_COUNT_DEF,
  parameter int PAGE_NUMBER_BITS = bbrc_pkg::PAGE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bbrc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [PAGE_NUMBER_BITS:0]         cfg_data_i,
  input  logic [PAGE_NUMBER_BITS-1:0]       block_page_i,
  input  logic [bbrc_pkg::ORDER_W-1:0]      block_order_i,
  input  bbrc_pkg::cmd_t                    cmd_i,
  output bbrc_pkg::sts_t                    sts_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output bbrc_pkg::kind_e                   out_kind_o,
  output logic [PAGE_NUMBER_BITS-1:0]       out_page_o,
  output logic [bbrc_pkg::ORDER_W-1:0]      out_order_o,
  output logic                              out_last_o
);

  localparam int SW    = PAGE_NUMBER_BITS + 1;
  localparam int OFF_W = (ORDER_COUNT < 16) ? ORDER_COUNT : 16;

  logic [PAGE_NUMBER_BITS-1:0]  first_q;
  logic [SW-1:0]                end_q;
  logic [SW-1:0]                s_q, s_d;
  logic [bbrc_pkg::ORDER_W-1:0] h_q, h_d;
  logic [bbrc_pkg::ORDER_W-1:0] top_q, top_d;
  logic [OFF_W-1:0]             o_q, o_d;

  logic                         out_valid_q;
  bbrc_pkg::kind_e              out_kind_q;
  logic [PAGE_NUMBER_BITS-1:0]  out_page_q;
  logic [bbrc_pkg::ORDER_W-1:0] out_order_q;
  logic                         out_last_q;

  logic [SW-1:0]                inc;
  logic [SW-1:0]                e_node;
  logic [SW-1:0]                first_ext;
  logic [OFF_W-1:0]             inc_off;
  logic [OFF_W-1:0]             o_nxt;
  logic [OFF_W-1:0]             span;
  logic [bbrc_pkg::ORDER_W-1:0] next_lvl;

  assign inc       = SW'(1) << h_q;
  assign e_node    = s_q + inc;
  assign first_ext = {1'b0, first_q};
  assign inc_off   = OFF_W'(1) << h_q;
  assign o_nxt     = o_q + inc_off;
  assign span      = OFF_W'(1) << top_q;

  // The next pending node is the right sibling whose level is the number of
  // trailing zeros of the new offset.
  always_comb begin
    next_lvl = '0;
    for (int i = OFF_W - 1; i >= 0; i--) begin
      if (o_nxt[i]) begin
        next_lvl = bbrc_pkg::ORDER_W'(i);
      end
    end
  end

  assign sts_o.order_bad  = (32'(h_q) >= ORDER_COUNT);
  assign sts_o.outside    = (e_node <= first_ext) || (s_q >= end_q);
  assign sts_o.in_range   = (s_q >= first_ext) && (e_node <= end_q);
  assign sts_o.at_end     = (o_nxt == span);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.level_zero = (h_q == '0);

  always_comb begin
    s_d   = s_q;
    h_d   = h_q;
    top_d = top_q;
    o_d   = o_q;
    if (cmd_i.load) begin
      s_d   = {1'b0, block_page_i};
      h_d   = block_order_i;
      top_d = block_order_i;
      o_d   = '0;
    end else if (cmd_i.advance) begin
      s_d = s_q + inc;
      o_d = o_nxt;
      h_d = next_lvl;
    end else if (cmd_i.descend) begin
      h_d = h_q - bbrc_pkg::ORDER_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    h_q   <= h_d;
    top_q <= top_d;
    o_q   <= o_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      end_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bbrc_pkg::CFG_FIRST_PAGE: first_q <= cfg_data_i[PAGE_NUMBER_BITS-1:0];
        bbrc_pkg::CFG_END_PAGE:   end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q  <= cmd_i.kind;
      out_page_q  <= s_q[PAGE_NUMBER_BITS-1:0];
      out_order_q <= h_q;
      out_last_q  <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_page_o  = out_page_q;
  assign out_order_o = out_order_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result word overwritten while waiting");
  a_advance_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.advance && !cmd_i.load) |=> (o_q != '0))
    else $error("walk offset did not move forward");
  a_descend_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.descend && !cmd_i.load) |=> (h_q == $past(h_q) - bbrc_pkg::ORDER_W'(1)))
    else $error("descend did not lower the level by one");
`endif

endmodule

// ----- hdl/bbrc_ctrl.sv -----
// Controller of the buddy block range carver: sequences the head result
// and the depth first walk over the split tree.
// Depends on bbrc_pkg; commands bbrc_dp through cmd_t and reads sts_t.
module bbrc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bbrc_pkg::sts_t sts_i,
  output bbrc_pkg::cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HEAD = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o.load    = 1'b0;
    cmd_o.emit    = 1'b0;
    cmd_o.kind    = bbrc_pkg::KIND_UNTOUCHED;
    cmd_o.last    = 1'b0;
    cmd_o.advance = 1'b0;
    cmd_o.descend = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.order_bad || sts_i.outside) begin
            cmd_o.kind = bbrc_pkg::KIND_UNTOUCHED;
            cmd_o.last = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            cmd_o.kind = bbrc_pkg::KIND_REMOVE;
            state_d    = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (sts_i.in_range || sts_i.outside) begin
          if (sts_i.out_free) begin
            cmd_o.emit    = 1'b1;
            cmd_o.kind    = sts_i.outside ? bbrc_pkg::KIND_GLOBAL : bbrc_pkg::KIND_DOMAIN;
            cmd_o.last    = sts_i.at_end;
            cmd_o.advance = 1'b1;
            if (sts_i.at_end) begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          cmd_o.descend = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("word emitted into a full output register");
  a_no_split_below_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && !sts_i.in_range && !sts_i.outside) |-> !sts_i.level_zero)
    else $error("single page found straddling the range");
  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (state_q == ST_IDLE))
    else $error("controller kept working after the final word");
`endif

endmodule

// ----- hdl/buddy_block_range_carver_top.sv -----
// The block is loaded when accepted; the head state then registers the first result word
// once the output register is free. An untouched block or one with a bad order gives one
// word; an overlapping block is then walked node by node over the split tree by the single
// node walker, a stalled output holds the walk, and a new block is taken after the last word.
// Reset clears both domain registers to zero, idles the controller and empties
// the output register.
module buddy_block_range_carver_top #(
  parameter int ORDER_COUNT      = bbrc_pkg::ORDER_COUNT_DEF,
  parameter int PAGE_NUMBER_BITS = bbrc_pkg::PAGE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bbrc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PAGE_NUMBER_BITS:0]      cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0 up: block_page, block_order, zero padding.
  input  logic [((PAGE_NUMBER_BITS + bbrc_pkg::ORDER_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0 up: piece_page, piece_order, zero padding.
  output logic [((PAGE_NUMBER_BITS + bbrc_pkg::ORDER_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // Fields from bit 0 up: action_kind.
  output logic [bbrc_pkg::KIND_W-1:0]    m_axis_tuser,
  output logic                           m_axis_tlast
);

  localparam int DATA_W = ((PAGE_NUMBER_BITS + bbrc_pkg::ORDER_W + 7) / 8) * 8;

  bbrc_pkg::cmd_t               cmd;
  bbrc_pkg::sts_t               sts;
  bbrc_pkg::kind_e              out_kind;
  logic [PAGE_NUMBER_BITS-1:0]  out_page;
  logic [bbrc_pkg::ORDER_W-1:0] out_order;

  bbrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bbrc_dp #(
    .ORDER_COUNT      (ORDER_COUNT),
    .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .block_page_i  (s_axis_tdata[PAGE_NUMBER_BITS-1:0]),
    .block_order_i (s_axis_tdata[PAGE_NUMBER_BITS +: bbrc_pkg::ORDER_W]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_kind_o    (out_kind),
    .out_page_o    (out_page),
    .out_order_o   (out_order),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = DATA_W'({out_order, out_page});
  assign m_axis_tuser = out_kind;

endmodule

// ----- tb/sv/buddy_block_range_carver_top_test.sv -----
// Self-checking testbench for buddy_block_range_carver_top.
// Drives free blocks and domain ranges, predicts the carved pieces in a scoreboard
// of its own, and checks every output word; depends on bbrc_pkg and the top level.
module buddy_block_range_carver_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE_BITS    = bbrc_pkg::PAGE_BITS_DEF;
  localparam int ORDERS       = bbrc_pkg::ORDER_COUNT_DEF;
  localparam int ORD_W        = bbrc_pkg::ORDER_W;
  localparam int DATA_W       = ((PAGE_BITS + ORD_W + 7) / 8) * 8;
  localparam int SETTLE_CYCLES = 2 + 4 * ORDERS + 8;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PRINT_LIMIT  = 40;

  typedef struct {
    bbrc_pkg::kind_e      kind;
    logic [PAGE_BITS-1:0] page;
    logic [ORD_W-1:0]     order;
    logic                 last;
  } piece_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [bbrc_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [PAGE_BITS:0]             cfg_data_i;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [DATA_W-1:0]              s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [DATA_W-1:0]              m_axis_tdata;
  logic [bbrc_pkg::KIND_W-1:0]    m_axis_tuser;
  logic                           m_axis_tlast;

  piece_t      expected_pieces[$];
  logic [63:0] dom_first;
  logic [63:0] dom_end;
  int          error_count;
  int          cycle_count;
  int          burst_left;
  bit          sender_gaps_on;
  bit          rx_stall_on;
  int          hold_request;
  int          hold_left;
  logic [15:0] stall_pattern;
  int          pattern_pos;

  buddy_block_range_carver_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("buddy_block_range_carver_top_test NOT OK");
      $finish;
    end
  end

  // Span tests on 64-bit values so that pieces past the top page do not wrap.
  function automatic bit span_outside(logic [63:0] s, int ord);
    logic [63:0] e;
    e = s + (64'd1 << ord);
    return (e <= dom_first) || (s >= dom_end);
  endfunction

  function automatic bit span_inside(logic [63:0] s, int ord);
    logic [63:0] e;
    e = s + (64'd1 << ord);
    return (s >= dom_first) && (e <= dom_end);
  endfunction

  function automatic void add_piece(bbrc_pkg::kind_e kind, logic [63:0] s, int ord);
    piece_t p;
    p.kind  = kind;
    p.page  = s[PAGE_BITS-1:0];
    p.order = ord[ORD_W-1:0];
    p.last  = 1'b0;
    expected_pieces.push_back(p);
  endfunction

  function automatic void carve_block(logic [PAGE_BITS-1:0] page, logic [ORD_W-1:0] ord);
    logic [63:0] pend_page[$];
    int          pend_ord[$];
    logic [63:0] s;
    int          o;
    piece_t      tail;
    s = {{(64 - PAGE_BITS){1'b0}}, page};
    o = ord;
    if (o >= ORDERS || span_outside(s, o)) begin
      add_piece(bbrc_pkg::KIND_UNTOUCHED, s, o);
    end else begin
      add_piece(bbrc_pkg::KIND_REMOVE, s, o);
      if (span_inside(s, o)) begin
        add_piece(bbrc_pkg::KIND_DOMAIN, s, o);
      end else if (o > 0) begin
        pend_page.push_back(s + (64'd1 << (o - 1)));
        pend_ord.push_back(o - 1);
        pend_page.push_back(s);
        pend_ord.push_back(o - 1);
      end
      // Right half is stacked beneath the left one, so the walk is depth first.
      while (pend_page.size() > 0) begin
        s = pend_page.pop_back();
        o = pend_ord.pop_back();
        if (span_outside(s, o)) begin
          add_piece(bbrc_pkg::KIND_GLOBAL, s, o);
        end else if (span_inside(s, o)) begin
          add_piece(bbrc_pkg::KIND_DOMAIN, s, o);
        end else if (o > 0) begin
          pend_page.push_back(s + (64'd1 << (o - 1)));
          pend_ord.push_back(o - 1);
          pend_page.push_back(s);
          pend_ord.push_back(o - 1);
        end
      end
    end
    tail = expected_pieces.pop_back();
    tail.last = 1'b1;
    expected_pieces.push_back(tail);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < PRINT_LIMIT) begin
      $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    error_count++;
  endtask

  always @(posedge clk_i) begin
    piece_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pieces.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata, 0);
      end else begin
        want = expected_pieces.pop_front();
        if (m_axis_tuser !== want.kind) begin
          report_mismatch("action kind", m_axis_tuser, want.kind);
        end
        if (m_axis_tdata[PAGE_BITS-1:0] !== want.page) begin
          report_mismatch("piece page", m_axis_tdata[PAGE_BITS-1:0], want.page);
        end
        if (m_axis_tdata[PAGE_BITS +: ORD_W] !== want.order) begin
          report_mismatch("piece order", m_axis_tdata[PAGE_BITS +: ORD_W], want.order);
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch("last flag", m_axis_tlast, want.last);
        end
      end
    end
  end

  // Receiver: a long hold-off when asked for, otherwise a random stall pattern when stalls are on, else always ready.
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (rx_stall_on) begin
      if (pattern_pos == 0) begin
        stall_pattern = ($urandom_range(0, 1) == 0) ? 16'($urandom | $urandom)
                                                     : 16'($urandom);
      end
      m_axis_tready <= stall_pattern[pattern_pos];
      pattern_pos = (pattern_pos + 1) % 16;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_block(logic [PAGE_BITS-1:0] page, logic [ORD_W-1:0] ord);
    logic [DATA_W-1:0] word;
    int                gap;
    word = '0;
    word[PAGE_BITS-1:0] = page;
    word[PAGE_BITS +: ORD_W] = ord;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    carve_block(page, ord);
    if (sender_gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        gap = $urandom_range(1, 8);
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  task automatic wait_block_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_pieces.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [bbrc_pkg::CFG_IDX_W-1:0] idx, logic [PAGE_BITS:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == bbrc_pkg::CFG_FIRST_PAGE) begin
      dom_first = {28'd0, value[PAGE_BITS-1:0]};
    end else begin
      dom_end = {27'd0, value};
    end
  endtask

  task automatic set_domain(logic [PAGE_BITS:0] first_page, logic [PAGE_BITS:0] end_page);
    wait_block_idle();
    write_register(bbrc_pkg::CFG_FIRST_PAGE, first_page);
    write_register(bbrc_pkg::CFG_END_PAGE, end_page);
  endtask

  task automatic send_random_block();
    logic [63:0]      base;
    logic [63:0]      page;
    logic [ORD_W-1:0] ord;
    int               pick;
    pick = $urandom_range(0, 99);
    ord = (pick < 6) ? ORD_W'($urandom_range(ORDERS, 15)) : ORD_W'($urandom_range(0, ORDERS - 1));
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      base = dom_first;
    end else if (pick < 8) begin
      base = dom_end;
    end else if (pick == 8) begin
      base = {$urandom, $urandom};
    end else begin
      base = dom_first + ((dom_end - dom_first) >> 1);
    end
    page = base - (64'd2 << ord) + 64'($urandom_range(0, 4 << ord));
    if ($urandom_range(0, 4) != 0) begin
      page = page & ~((64'd1 << ord) - 64'd1);
    end
    send_block(page[PAGE_BITS-1:0], ord);
  endtask

  task automatic pick_idling();
    sender_gaps_on = ($urandom_range(0, 3) != 0);
    rx_stall_on    = ($urandom_range(0, 3) != 0);
    burst_left     = $urandom_range(1, 12);
  endtask

  task automatic test_reset_range();
    send_block('0, 4'd0);
    send_block({PAGE_BITS{1'b1}}, 4'd10);
    send_block('0, 4'd15);
    send_block(PAGE_BITS'({$urandom, $urandom}), 4'd5);
  endtask

  task automatic test_directed();
    set_domain(37'h0_0000_1003, 37'h0_0000_1ff5);
    send_block(36'h0_0000_0000, 4'd10);
    send_block(36'h0_0000_2000, 4'd10);
    send_block(36'h0_0000_1400, 4'd10);
    send_block(36'h0_0000_1000, 4'd10);
    send_block(36'h0_0000_1c00, 4'd10);
    send_block(36'h0_0000_1003, 4'd0);
    send_block(36'h0_0000_1002, 4'd0);
    send_block(36'h0_0000_1400, 4'd11);
    send_block(36'h0_0000_1400, 4'd15);
    send_block(36'h0_0000_0ffd, 4'd4);
    send_block(36'hf_ffff_ffff, 4'd0);
    // A range inside one block: both boundaries cut the same block.
    set_domain(37'h0_0000_1003, 37'h0_0000_13f5);
    send_block(36'h0_0000_1000, 4'd10);
    send_block(36'h0_0000_1000, 4'd3);
    // Top of the page space, where pieces of an unaligned block wrap.
    set_domain(37'h0_f_ffff_fed4, 37'h1_0_0000_0000);
    send_block(36'hf_ffff_ff9c, 4'd10);
    send_block(36'hf_ffff_fc00, 4'd10);
    // Inverted and empty ranges give no domain pieces: only the removal word and global pieces.
    set_domain(37'h0_0000_0500, 37'h0_0000_0480);
    send_block(36'h0_0000_0400, 4'd9);
    set_domain(37'h0_0000_0480, 37'h0_0000_0480);
    send_block(36'h0_0000_0400, 4'd8);
  endtask

  task automatic test_random_ranges();
    logic [PAGE_BITS:0] first_page;
    logic [PAGE_BITS:0] end_page;
    logic [63:0]        wide_end;
    for (int phase = 0; phase < 7; phase++) begin
      first_page = {1'b0, PAGE_BITS'({$urandom, $urandom})};
      case (phase)
        0: begin
          first_page = 37'($urandom_range(0, 1 << 20));
          end_page   = first_page + 37'($urandom_range(1, 3000));
        end
        1: begin
          first_page = '0;
          end_page   = 37'h1_0_0000_0000;
        end
        2: begin
          first_page = 37'h0_f_ffff_ffff;
          end_page   = 37'h1_0_0000_0000;
        end
        3: begin
          end_page = first_page - 37'($urandom_range(1, 2000));
        end
        4: begin
          end_page = first_page;
        end
        5: begin
          wide_end = {27'd0, first_page} + 64'($urandom_range(1, 1 << 20));
          end_page = (wide_end > 64'h10_0000_0000) ? 37'h1_0_0000_0000 : wide_end[PAGE_BITS:0];
        end
        default: begin
          first_page = '0;
          end_page   = 37'($urandom_range(1, 5000));
        end
      endcase
      set_domain(first_page, end_page);
      pick_idling();
      repeat (50) send_random_block();
    end
  endtask

  task automatic test_backpressure();
    logic [PAGE_BITS:0] first_page;
    first_page = {1'b0, PAGE_BITS'({$urandom, $urandom})};
    set_domain(first_page, first_page + 37'($urandom_range(100, 3000)));
    sender_gaps_on = 1'b0;
    rx_stall_on    = 1'b1;
    hold_request   = 400;
    repeat (30) send_random_block();
    wait_block_idle();
    pick_idling();
    repeat (10) send_random_block();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = bbrc_pkg::CFG_FIRST_PAGE;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    dom_first     = '0;
    dom_end       = '0;
    error_count   = 0;
    cycle_count   = 0;
    hold_request  = 0;
    hold_left     = 0;
    pattern_pos   = 0;
    stall_pattern = '1;
    sender_gaps_on = 1'b0;
    rx_stall_on    = 1'b0;
    burst_left     = 1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_range();
    test_directed();
    test_random_ranges();
    test_backpressure();
    wait_block_idle();

    if (error_count == 0) begin
      $display("buddy_block_range_carver_top_test OK");
    end else begin
      $display("buddy_block_range_carver_top_test NOT OK");
    end
    $finish;
  end

endmodule
